/* hdl/u8u16_pkg.sv */
`default_nettype none

package u8u16_pkg;

   localparam int LENGTH_BITS   = 24;
   localparam int CAP_BITS      = 24;
   localparam int REPORT_BITS   = 24;
   localparam int SUM_BITS      = ((LENGTH_BITS > CAP_BITS) ? LENGTH_BITS : CAP_BITS) + 2;
   localparam int UNIT_BITS     = 16;
   localparam int CODE_BITS     = 21;
   localparam int BYTE_BITS     = 8;
   localparam int CSR_DATA_BITS = 24;
   localparam int MAX_RESULTS   = 3;
   localparam int RES_CNT_BITS  = 2;
   localparam int FIFO_DEPTH    = 8;
   localparam int PTR_BITS      = $clog2(FIFO_DEPTH);
   localparam int FILL_BITS     = $clog2(FIFO_DEPTH + 1);

   localparam logic [CODE_BITS-1:0] SURR_FIRST = 21'h00D800;
   localparam logic [CODE_BITS-1:0] SURR_LAST  = 21'h00DFFF;
   localparam logic [CODE_BITS-1:0] CODE_MAX   = 21'h10FFFF;
   localparam logic [CODE_BITS-1:0] PLANE1     = 21'h010000;

   localparam logic [UNIT_BITS-1:0] HIGH_BASE = 16'hD800;
   localparam logic [UNIT_BITS-1:0] LOW_BASE  = 16'hDC00;

   localparam logic [BYTE_BITS-1:0] CONT_MASK  = 8'hC0;
   localparam logic [BYTE_BITS-1:0] CONT_TAG   = 8'h80;
   localparam logic [BYTE_BITS-1:0] LEAD2_MASK = 8'hE0;
   localparam logic [BYTE_BITS-1:0] LEAD2_TAG  = 8'hC0;
   localparam logic [BYTE_BITS-1:0] LEAD3_MASK = 8'hF0;
   localparam logic [BYTE_BITS-1:0] LEAD3_TAG  = 8'hE0;
   localparam logic [BYTE_BITS-1:0] LEAD4_MASK = 8'hF8;
   localparam logic [BYTE_BITS-1:0] LEAD4_TAG  = 8'hF0;

   localparam logic [LENGTH_BITS-1:0] LEN_MAX    = '1;
   localparam logic [REPORT_BITS-1:0] REPORT_MAX = '1;
   localparam logic [CAP_BITS-1:0]    CAP_RESET  = '1;

   typedef enum logic [0:0] {
      CSR_CAPACITY = 1'b0,
      CSR_MEASURE  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [UNIT_BITS-1:0]   code_unit;
      logic                   unit_valid;
      logic                   final_report;
      logic                   status;
      logic [REPORT_BITS-1:0] total_length;
      logic                   last_of_run;
   } rsp_item_type;

   typedef struct packed {
      logic [RES_CNT_BITS-1:0]             count;
      rsp_item_type [MAX_RESULTS-1:0]      item;
   } push_type;

   function automatic rsp_item_type make_unit(input logic [UNIT_BITS-1:0] unit,
                                              input logic last);
      rsp_item_type r;
      r              = '0;
      r.code_unit    = unit;
      r.unit_valid   = 1'b1;
      r.last_of_run  = last;
      return r;
   endfunction

   function automatic rsp_item_type make_report(input logic st,
                                                input logic [REPORT_BITS-1:0] len);
      rsp_item_type r;
      r              = '0;
      r.final_report = 1'b1;
      r.status       = st;
      r.total_length = len;
      r.last_of_run  = 1'b1;
      return r;
   endfunction

   function automatic logic [LENGTH_BITS-1:0] sat_len(input logic [SUM_BITS-1:0] s);
      logic [LENGTH_BITS-1:0] r;
      if (s > SUM_BITS'(LEN_MAX)) begin
         r = LEN_MAX;
      end else begin
         r = s[LENGTH_BITS-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* hdl/u8u16_req_if.sv */
`default_nettype none

interface u8u16_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       byte_present;
   logic       end_of_text;

   modport source (output valid, output text_byte, output byte_present,
                   output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input byte_present,
                   input end_of_text, output ready);
endinterface

`default_nettype wire

/* hdl/u8u16_rsp_if.sv */
`default_nettype none

interface u8u16_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        unit_valid;
   logic        final_report;
   logic        status;
   logic [23:0] total_length;
   logic        last_of_run;

   modport source (output valid, output code_unit, output unit_valid,
                   output final_report, output status, output total_length,
                   output last_of_run, input ready);
   modport sink   (input valid, input code_unit, input unit_valid,
                   input final_report, input status, input total_length,
                   input last_of_run, output ready);
endinterface

`default_nettype wire

/* hdl/u8u16_decode.sv */
`default_nettype none

module u8u16_decode (
   input  wire logic                          clock,
   input  wire logic                          reset,
   u8u16_req_if.sink                          req_chan,
   input  wire logic [u8u16_pkg::CAP_BITS-1:0] capacity,
   input  wire logic                          measure,
   input  wire logic                          room,
   output u8u16_pkg::push_type                push
);
   import u8u16_pkg::*;

   logic                   item_valid_ff;
   logic [BYTE_BITS-1:0]   byte_ff;
   logic                   present_ff;
   logic                   end_ff;

   logic [CODE_BITS-1:0]   partial_ff,  partial_in;
   logic [1:0]             pending_ff,  pending_in;
   logic [LENGTH_BITS-1:0] written_ff,  written_in;
   logic                   error_ff,    error_in;

   logic                   go;
   logic                   take;
   logic                   finish;
   logic [CODE_BITS-1:0]   cp;
   logic [CODE_BITS-1:0]   cp_cont;
   logic [CODE_BITS-1:0]   offset;
   logic                   bad_cp;
   logic                   pair;
   logic [UNIT_BITS-1:0]   unit_a;
   logic [UNIT_BITS-1:0]   unit_b;
   logic [SUM_BITS-1:0]    sum2;
   logic [SUM_BITS-1:0]    sum4;
   logic [SUM_BITS-1:0]    cap_ext;
   logic                   fit1;
   logic                   fit2;
   logic                   emit_a;
   logic                   emit_b;
   logic [LENGTH_BITS-1:0] step_len;
   logic                   step_err;
   logic                   report_err;
   logic [SUM_BITS-1:0]    len_ext;
   logic [REPORT_BITS-1:0] report_len;

   assign go             = item_valid_ff && room;
   assign req_chan.ready = !item_valid_ff || go;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         item_valid_ff <= req_chan.valid;
      end
      if (req_chan.valid && req_chan.ready) begin
         byte_ff    <= req_chan.text_byte;
         present_ff <= req_chan.byte_present;
         end_ff     <= req_chan.end_of_text;
      end
   end

   assign take    = present_ff && !error_ff;
   assign cp_cont = {partial_ff[CODE_BITS-7:0], byte_ff[5:0]};
   assign offset  = cp - PLANE1;
   assign bad_cp  = ((cp >= SURR_FIRST) && (cp <= SURR_LAST)) || (cp > CODE_MAX);
   assign pair    = cp >= PLANE1;
   assign unit_a  = pair ? (HIGH_BASE + UNIT_BITS'(offset[19:10])) : cp[UNIT_BITS-1:0];
   assign unit_b  = LOW_BASE | UNIT_BITS'(offset[9:0]);
   assign sum2    = SUM_BITS'(written_ff) + SUM_BITS'(2);
   assign sum4    = SUM_BITS'(written_ff) + SUM_BITS'(4);
   assign cap_ext = SUM_BITS'(capacity);
   assign fit1    = sum2 <= cap_ext;
   assign fit2    = sum4 <= cap_ext;

   // code point completed by this byte
   always_comb begin
      finish = 1'b0;
      cp     = cp_cont;
      if (take) begin
         if (pending_ff == 2'd0) begin
            finish = !byte_ff[7];
            cp     = CODE_BITS'(byte_ff);
         end else begin
            finish = ((byte_ff & CONT_MASK) == CONT_TAG) && (pending_ff == 2'd1);
         end
      end
   end

   always_comb begin
      partial_in = partial_ff;
      pending_in = pending_ff;
      step_err   = error_ff;
      if (take) begin
         if (pending_ff == 2'd0) begin
            if ((byte_ff & LEAD2_MASK) == LEAD2_TAG) begin
               partial_in = CODE_BITS'(byte_ff[4:0]);
               pending_in = 2'd1;
            end else if ((byte_ff & LEAD3_MASK) == LEAD3_TAG) begin
               partial_in = CODE_BITS'(byte_ff[3:0]);
               pending_in = 2'd2;
            end else if ((byte_ff & LEAD4_MASK) == LEAD4_TAG) begin
               partial_in = CODE_BITS'(byte_ff[2:0]);
               pending_in = 2'd3;
            end else if (byte_ff[7]) begin
               step_err = 1'b1;
            end
         end else if ((byte_ff & CONT_MASK) != CONT_TAG) begin
            step_err = 1'b1;
         end else begin
            partial_in = cp_cont;
            pending_in = pending_ff - 2'd1;
         end
      end

      emit_a   = 1'b0;
      emit_b   = 1'b0;
      step_len = written_ff;
      if (finish) begin
         if (bad_cp) begin
            step_err = 1'b1;
         end else if (measure) begin
            step_len = pair ? sat_len(sum4) : sat_len(sum2);
         end else if (!fit1) begin
            step_err = 1'b1;
         end else if (!pair) begin
            emit_a   = 1'b1;
            step_len = sat_len(sum2);
         end else if (!fit2) begin
            emit_a   = 1'b1;
            step_len = sat_len(sum2);
            step_err = 1'b1;
         end else begin
            emit_a   = 1'b1;
            emit_b   = 1'b1;
            step_len = sat_len(sum4);
         end
      end

      report_err = step_err || (pending_in != 2'd0);
      len_ext    = SUM_BITS'(step_len);
      if (len_ext > SUM_BITS'(REPORT_MAX)) begin
         report_len = REPORT_MAX;
      end else begin
         report_len = len_ext[REPORT_BITS-1:0];
      end

      if (end_ff) begin
         partial_in = '0;
         pending_in = 2'd0;
         written_in = '0;
         error_in   = 1'b0;
      end else begin
         written_in = step_len;
         error_in   = step_err;
      end

      push.item[0] = emit_a ? make_unit(unit_a, !emit_b && !end_ff)
                            : make_report(report_err, report_len);
      push.item[1] = emit_b ? make_unit(unit_b, !end_ff)
                            : make_report(report_err, report_len);
      push.item[2] = make_report(report_err, report_len);
      if (go) begin
         push.count = RES_CNT_BITS'(emit_a) + RES_CNT_BITS'(emit_b)
                    + RES_CNT_BITS'(end_ff);
      end else begin
         push.count = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         pending_ff <= 2'd0;
         written_ff <= '0;
         error_ff   <= 1'b0;
      end else if (go) begin
         partial_ff <= partial_in;
         pending_ff <= pending_in;
         written_ff <= written_in;
         error_ff   <= error_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/u8u16_fifo.sv */
`default_nettype none

module u8u16_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire u8u16_pkg::push_type push,
   input  wire logic             pop,
   output u8u16_pkg::rsp_item_type head,
   output logic                  head_valid,
   output logic                  room
);
   import u8u16_pkg::*;

   rsp_item_type               mem_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [FILL_BITS-1:0]       fill_ff,   fill_in;
   logic [PTR_BITS-1:0]        wr_addr [MAX_RESULTS];

   always_comb begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         wr_addr[k] = wr_ptr_ff + PTR_BITS'(k);
      end
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
      fill_in   = fill_ff + FILL_BITS'(push.count) - FILL_BITS'(pop);
   end

   assign head       = mem_ff[rd_ptr_ff];
   assign head_valid = fill_ff != '0;
   assign room       = fill_ff <= FILL_BITS'(FIFO_DEPTH - MAX_RESULTS);

   always_ff @(posedge clock) begin
      for (int i = 0; i < FIFO_DEPTH; i++) begin
         for (int k = 0; k < MAX_RESULTS; k++) begin
            if ((RES_CNT_BITS'(k) < push.count) && (wr_addr[k] == PTR_BITS'(i))) begin
               mem_ff[i] <= push.item[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/utf8_to_utf16le_transcoder.sv */
// channel | dir | handshake         | word
// --------+-----+-------------------+-------------------------------------------
// req     | in  | valid/ready       | text_byte, byte_present, end_of_text
// rsp     | out | valid/ready       | code_unit, unit_valid, final_report,
//         |     |                   | status, total_length, last_of_run
// csr     | in  | write enable only | csr_index, csr_write_data
//
// One input word per cycle while the result queue has room. A taken word is
// registered, then decoded; its results (up to three) go into an 8-entry queue
// whose head drives rsp; it drains one result per cycle while rsp is ready.
// req stalls while fewer than three entries are free. Synchronous reset empties
// the queue, clears decoder state and sets capacity to full; no clearing pass.
`default_nettype none

module utf8_to_utf16le_transcoder (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   u8u16_req_if.sink                                  req_chan,
   u8u16_rsp_if.source                                rsp_chan,
   input  wire logic                                  csr_write_en,
   input  wire u8u16_pkg::csr_index_type              csr_index,
   input  wire logic [u8u16_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);
   import u8u16_pkg::*;

   logic [CAP_BITS-1:0] capacity_ff;
   logic                measure_ff;
   logic                room;
   push_type            push;
   rsp_item_type        head;
   logic                head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
         measure_ff  <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_CAPACITY: capacity_ff <= csr_write_data[CAP_BITS-1:0];
            CSR_MEASURE:  measure_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   u8u16_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .capacity (capacity_ff),
      .measure  (measure_ff),
      .room     (room),
      .push     (push)
   );

   u8u16_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (head_valid && rsp_chan.ready),
      .head       (head),
      .head_valid (head_valid),
      .room       (room)
   );

   assign rsp_chan.valid        = head_valid;
   assign rsp_chan.code_unit    = head.code_unit;
   assign rsp_chan.unit_valid   = head.unit_valid;
   assign rsp_chan.final_report = head.final_report;
   assign rsp_chan.status       = head.status;
   assign rsp_chan.total_length = head.total_length;
   assign rsp_chan.last_of_run  = head.last_of_run;

endmodule

`default_nettype wire

/* hdl/u8u16_checker.sv */
`default_nettype none

module u8u16_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] code_unit,
   input wire logic        unit_valid,
   input wire logic        final_report,
   input wire logic        status,
   input wire logic [23:0] total_length,
   input wire logic        last_of_run
);

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (unit_valid ^ final_report))
      else $error("word is neither a unit nor a report, or both");

   a_report_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && final_report |-> last_of_run)
      else $error("report not marked last of run");

   a_unit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && unit_valid |-> !status && (total_length == 24'd0))
      else $error("unit word carries status or length");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(code_unit)
                                  && $stable(last_of_run))
      else $error("stalled rsp word changed");

endmodule

bind utf8_to_utf16le_transcoder u8u16_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .code_unit    (rsp_chan.code_unit),
   .unit_valid   (rsp_chan.unit_valid),
   .final_report (rsp_chan.final_report),
   .status       (rsp_chan.status),
   .total_length (rsp_chan.total_length),
   .last_of_run  (rsp_chan.last_of_run)
);

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
   import u8u16_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 80;
   localparam int RANDOM_WORDS  = 150;

   class transcode_scoreboard;
      rsp_item_type           due_words[$];
      rsp_item_type           fresh[$];
      logic [CAP_BITS-1:0]    capacity;
      logic                   measure;
      logic [CODE_BITS-1:0]   partial;
      logic [1:0]             left;
      logic [LENGTH_BITS-1:0] written;
      logic                   text_failed;
      int                     mismatches;

      function new();
         capacity    = '1;
         measure     = 1'b0;
         partial     = '0;
         left        = '0;
         written     = '0;
         text_failed = 1'b0;
         mismatches  = 0;
      endfunction

      function void set_csr(csr_index_type idx, logic [CSR_DATA_BITS-1:0] d);
         case (idx)
            CSR_CAPACITY: begin
               capacity = d[CAP_BITS-1:0];
            end
            CSR_MEASURE: begin
               measure = d[0];
            end
            default: begin
            end
         endcase
      endfunction

      function bit put_unit(logic [UNIT_BITS-1:0] u);
         rsp_item_type w;
         logic [25:0]  sum;
         sum = {2'b00, written} + 26'd2;
         if (!measure) begin
            if (sum > {2'b00, capacity}) begin
               return 1'b0;
            end
            w           = '0;
            w.code_unit  = u;
            w.unit_valid = 1'b1;
            fresh.push_back(w);
         end
         written = (sum > {2'b00, LEN_MAX}) ? LEN_MAX : sum[LENGTH_BITS-1:0];
         return 1'b1;
      endfunction

      function void close_code(logic [CODE_BITS-1:0] cp);
         logic [CODE_BITS-1:0] off;
         if ((cp >= SURR_FIRST && cp <= SURR_LAST) || cp > CODE_MAX) begin
            text_failed = 1'b1;
            return;
         end
         if (cp < PLANE1) begin
            if (!put_unit(cp[15:0])) begin
               text_failed = 1'b1;
            end
            return;
         end
         off = cp - PLANE1;
         if (!put_unit(HIGH_BASE + {6'd0, off[19:10]})) begin
            text_failed = 1'b1;
            return;
         end
         if (!put_unit(LOW_BASE + {6'd0, off[9:0]})) begin
            text_failed = 1'b1;
         end
      endfunction

      function void feed_byte(logic [7:0] b);
         if (left == 2'd0) begin
            if (b < 8'h80) begin
               close_code({13'd0, b});
            end else if ((b & 8'hE0) == 8'hC0) begin
               partial = {16'd0, b[4:0]};
               left    = 2'd1;
            end else if ((b & 8'hF0) == 8'hE0) begin
               partial = {17'd0, b[3:0]};
               left    = 2'd2;
            end else if ((b & 8'hF8) == 8'hF0) begin
               partial = {18'd0, b[2:0]};
               left    = 2'd3;
            end else begin
               text_failed = 1'b1;
            end
            return;
         end
         if (b[7:6] != 2'b10) begin
            text_failed = 1'b1;
            return;
         end
         partial = {partial[14:0], b[5:0]};
         left    = left - 2'd1;
         if (left == 2'd0) begin
            close_code(partial);
         end
      endfunction

      function void note_word(logic [7:0] b, logic present, logic eot);
         rsp_item_type w;
         fresh.delete();
         if (present && !text_failed) begin
            feed_byte(b);
         end
         if (eot) begin
            if (left != 2'd0) begin
               text_failed = 1'b1;
            end
            w              = '0;
            w.final_report = 1'b1;
            w.status       = text_failed;
            w.total_length = written;
            fresh.push_back(w);
            partial     = '0;
            left        = '0;
            written     = '0;
            text_failed = 1'b0;
         end
         if (fresh.size() > 0) begin
            fresh[fresh.size()-1].last_of_run = 1'b1;
         end
         foreach (fresh[i]) begin
            due_words.push_back(fresh[i]);
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (due_words.size() == 0) begin
            $error("unexpected result word: code_unit %h final_report %b",
                   got.code_unit, got.final_report);
            mismatches++;
            return;
         end
         want = due_words.pop_front();
         if (got.code_unit !== want.code_unit) begin
            $error("code_unit: expected %h, actual %h", want.code_unit, got.code_unit);
            mismatches++;
         end
         if (got.unit_valid !== want.unit_valid) begin
            $error("unit_valid: expected %b, actual %b", want.unit_valid, got.unit_valid);
            mismatches++;
         end
         if (got.final_report !== want.final_report) begin
            $error("final_report: expected %b, actual %b",
                   want.final_report, got.final_report);
            mismatches++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %b, actual %b", want.status, got.status);
            mismatches++;
         end
         if (got.total_length !== want.total_length) begin
            $error("total_length: expected %h, actual %h",
                   want.total_length, got.total_length);
            mismatches++;
         end
         if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %b, actual %b", want.last_of_run, got.last_of_run);
            mismatches++;
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       csr_write_en;
   csr_index_type              csr_index;
   logic [CSR_DATA_BITS-1:0]   csr_write_data;
   transcode_scoreboard        sb = new();
   int                         burst_left;
   int                         rand_words;
   int                         quiet_cycles;
   bit                         hold_off_go;

   u8u16_req_if req_bus();
   u8u16_rsp_if rsp_bus();

   utf8_to_utf16le_transcoder u_top (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_bus),
      .rsp_chan       (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic send_word(logic [7:0] b, logic present, logic eot);
      int gap;
      @(negedge clock);
      req_bus.valid        <= 1'b1;
      req_bus.text_byte    <= b;
      req_bus.byte_present <= present;
      req_bus.end_of_text  <= eot;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_word(b, present, eot);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 10);
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_text(logic [7:0] bytes[$], bit bare_end, bit noisy);
      foreach (bytes[i]) begin
         if (noisy && $urandom_range(0, 19) == 0) begin
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         end
         send_word(bytes[i], 1'b1, !bare_end && i == bytes.size() - 1);
      end
      if (bare_end || bytes.size() == 0) begin
         send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_BITS-1:0] d);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= d;
      sb.set_csr(idx, d);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.due_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic add_code(inout logic [7:0] bytes[$], input logic [20:0] cp, input int nb);
      case (nb)
         1: bytes.push_back({1'b0, cp[6:0]});
         2: begin
            bytes.push_back({3'b110, cp[10:6]});
            bytes.push_back({2'b10, cp[5:0]});
         end
         3: begin
            bytes.push_back({4'b1110, cp[15:12]});
            bytes.push_back({2'b10, cp[11:6]});
            bytes.push_back({2'b10, cp[5:0]});
         end
         default: begin
            bytes.push_back({5'b11110, cp[20:18]});
            bytes.push_back({2'b10, cp[17:12]});
            bytes.push_back({2'b10, cp[11:6]});
            bytes.push_back({2'b10, cp[5:0]});
         end
      endcase
   endtask

   task automatic send_random_text(inout int count);
      logic [7:0]  bytes[$];
      logic [20:0] cp;
      int          nchars;
      int          nb;
      int          kind;
      int          pos;
      bit          bare;
      nchars = $urandom_range(1, 8);
      repeat (nchars) begin
         kind = $urandom_range(0, 9);
         if (kind <= 2) begin
            nb = 1;
            cp = 21'($urandom_range(0, 'h7F));
         end else if (kind <= 4) begin
            nb = 2;
            cp = 21'($urandom_range('h80, 'h7FF));
         end else if (kind <= 6) begin
            nb = 3;
            cp = 21'($urandom_range('h800, 'hFFFF));
         end else if (kind == 8) begin
            case ($urandom_range(0, 2))
               0: begin
                  nb = 3;
                  cp = 21'($urandom_range('hD800, 'hDFFF));
               end
               1: begin
                  nb = 4;
                  cp = 21'($urandom_range('h110000, 'h1FFFFF));
               end
               default: begin
                  nb = $urandom_range(2, 4);
                  cp = 21'($urandom_range(0, 'h7FF));
               end
            endcase
         end else begin
            nb = 4;
            cp = 21'($urandom_range('h10000, 'h10FFFF));
         end
         add_code(bytes, cp, nb);
      end
      if ($urandom_range(0, 99) < 15) begin
         pos = $urandom_range(0, bytes.size() - 1);
         case ($urandom_range(0, 2))
            0: bytes[pos] = 8'($urandom_range(0, 255));
            1: void'(bytes.pop_back());
            default: bytes.insert(pos, 8'($urandom_range(0, 255)));
         endcase
      end
      bare = 1'($urandom_range(0, 1));
      send_text(bytes, bare, 1'b1);
      count += bytes.size() + ((bare || bytes.size() == 0) ? 1 : 0);
   endtask

   // receiver: own stall pattern, plus one long hold-off on request
   initial begin : rsp_side
      int mode;
      int mode_left;
      mode          = 0;
      mode_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_go) begin
            hold_off_go = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(10, 60);
         end
         mode_left--;
         case (mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= 1'($urandom_range(0, 1));
            2: rsp_bus.ready <= (mode_left % 4 == 0);
            default: rsp_bus.ready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   always @(posedge clock) begin : rsp_monitor
      rsp_item_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.code_unit    = rsp_bus.code_unit;
         got.unit_valid   = rsp_bus.unit_valid;
         got.final_report = rsp_bus.final_report;
         got.status       = rsp_bus.status;
         got.total_length = rsp_bus.total_length;
         got.last_of_run  = rsp_bus.last_of_run;
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      int                       ph;
      int                       phase_words;
      logic [CAP_BITS-1:0]      cap;
      logic                     meas;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.text_byte    = '0;
      req_bus.byte_present = 1'b0;
      req_bus.end_of_text  = 1'b0;
      csr_write_en         = 1'b0;
      csr_index            = CSR_CAPACITY;
      csr_write_data       = '0;
      burst_left           = 0;
      rand_words           = 0;
      quiet_cycles         = 0;
      hold_off_go          = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: every lead length, overlong, surrogate, out of range,
      // bad lead, bad continuation, truncation, idle word, bare end
      send_word(8'h00, 1'b1, 1'b0);
      send_word(8'h5A, 1'b0, 1'b0);
      send_text('{8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80},
                1'b1, 1'b0);
      send_text('{8'hC0, 8'h80}, 1'b0, 1'b0);
      send_text('{8'hED, 8'hA0, 8'h80, 8'h41}, 1'b0, 1'b0);
      send_text('{8'hF4, 8'h90, 8'h80, 8'h80}, 1'b0, 1'b0);
      send_text('{8'h7F, 8'hFF}, 1'b0, 1'b0);
      send_text('{8'hE2, 8'h41}, 1'b0, 1'b0);
      send_text('{8'hC2}, 1'b1, 1'b0);
      send_word(8'hFF, 1'b0, 1'b1);

      ph = 0;
      while (ph < 7 || rand_words < RANDOM_WORDS) begin
         drain_results();
         case (ph % 7)
            0: begin
               cap  = '1;
               meas = 1'b0;
            end
            1: begin
               cap  = '0;
               meas = 1'b0;
            end
            2: begin
               cap  = 24'd2;
               meas = 1'b0;
            end
            3: begin
               cap  = '1;
               meas = 1'b1;
            end
            4: begin
               cap  = '0;
               meas = 1'b1;
            end
            5: begin
               cap  = 24'($urandom_range(1, 60));
               meas = 1'b0;
            end
            default: begin
               cap  = 24'($urandom_range(0, 24'hFFFFFF));
               meas = 1'($urandom_range(0, 1));
            end
         endcase
         write_csr(CSR_CAPACITY, cap);
         write_csr(CSR_MEASURE, {23'd0, meas});
         if (ph == 0 || ph == 5) begin
            hold_off_go = 1'b1;
         end
         if (ph % 7 == 2) begin
            // second half of a pair does not fit
            send_text('{8'hF0, 8'h9F, 8'h98, 8'h80}, 1'b0, 1'b0);
         end
         phase_words = 0;
         while (phase_words < 20) begin
            send_random_text(phase_words);
            if (ph == 3 && phase_words < 15) begin
               drain_results();
            end
         end
         rand_words += phase_words;
         ph++;
      end

      drain_results();
      if (sb.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
